[hdl/backslash_escape_decoder_core_macros.svh]
// assertion helpers shared by the decoder rtl
// each macro samples on clk and is disabled while rst_n is low
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSD_ASSERT_IMP(lbl, ante, cons, msg)
`define BSD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/bsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

    // decode modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX0  = 2'd2;
    localparam logic [1:0] MODE_HEX1  = 2'd3;

    // characters
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] BYTE_NL     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] HEX_ALPHA   = 8'd10;

    // result queue
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = 2;
    localparam logic [2:0]  FIFO_LIMIT = 3'd2;  // accept only with room for two

    // push counts
    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } entry_t;

    typedef struct packed {
        logic [1:0] count;
        entry_t     e0;
        entry_t     e1;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t       h;
        logic [7:0] t;
        h.ok  = 1'b0;
        h.val = 4'h0;
        t     = 8'h00;
        if (b >= CHAR_0 && b <= CHAR_9) begin
            t    = b - CHAR_0;
            h.ok = 1'b1;
        end else if (b >= CHAR_LA && b <= CHAR_LF) begin
            t    = b - CHAR_LA + HEX_ALPHA;
            h.ok = 1'b1;
        end else if (b >= CHAR_UA && b <= CHAR_UF) begin
            t    = b - CHAR_UA + HEX_ALPHA;
            h.ok = 1'b1;
        end
        h.val = t[3:0];
        return h;
    endfunction

endpackage

`default_nettype wire

[hdl/bsd_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsd_decoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output bsd_pkg::push_t     push,
    output logic [1:0]         mode
);

    logic [1:0]    mode_reg;
    logic [1:0]    mode_next;
    logic [3:0]    hi_reg;
    logic [3:0]    hi_next;
    bsd_pkg::hex_t hv;
    logic          plain_push;
    logic [1:0]    plain_mode;
    logic [1:0]    n;
    logic [7:0]    d0;
    logic [7:0]    d1;

    assign hv = bsd_pkg::hex_value(in_byte);

    // ordinary text handling: an unfinished backslash opens an escape
    assign plain_push = !(in_byte == bsd_pkg::CHAR_BSLASH && !in_last);
    assign plain_mode = plain_push ? bsd_pkg::MODE_PLAIN : bsd_pkg::MODE_ESC;

    always_comb
    begin
        n         = bsd_pkg::PUSH_NONE;
        d0        = in_byte;
        d1        = in_byte;
        mode_next = mode_reg;
        hi_next   = hi_reg;
        case (mode_reg)
            bsd_pkg::MODE_PLAIN:
            begin
                n         = plain_push ? bsd_pkg::PUSH_ONE : bsd_pkg::PUSH_NONE;
                mode_next = plain_mode;
            end
            bsd_pkg::MODE_ESC:
            begin
                mode_next = bsd_pkg::MODE_PLAIN;
                n         = bsd_pkg::PUSH_ONE;
                case (in_byte)
                    bsd_pkg::CHAR_N:      d0 = bsd_pkg::BYTE_NL;
                    bsd_pkg::CHAR_R:      d0 = bsd_pkg::BYTE_CR;
                    bsd_pkg::CHAR_T:      d0 = bsd_pkg::BYTE_TAB;
                    bsd_pkg::CHAR_E:      d0 = bsd_pkg::BYTE_ESC;
                    bsd_pkg::CHAR_BSLASH: d0 = bsd_pkg::CHAR_BSLASH;
                    bsd_pkg::CHAR_X:
                    begin
                        d0 = bsd_pkg::CHAR_X;
                        if (!in_last)
                        begin
                            n         = bsd_pkg::PUSH_NONE;
                            mode_next = bsd_pkg::MODE_HEX0;
                        end
                    end
                    default:
                    begin
                        // unknown escape keeps the backslash
                        n  = bsd_pkg::PUSH_TWO;
                        d0 = bsd_pkg::CHAR_BSLASH;
                    end
                endcase
            end
            bsd_pkg::MODE_HEX0:
            begin
                if (hv.ok)
                begin
                    if (in_last)
                    begin
                        n         = bsd_pkg::PUSH_ONE;
                        d0        = {4'h0, hv.val};
                        mode_next = bsd_pkg::MODE_PLAIN;
                    end
                    else
                    begin
                        hi_next   = hv.val;
                        mode_next = bsd_pkg::MODE_HEX1;
                    end
                end
                else
                begin
                    d0        = bsd_pkg::CHAR_X;
                    n         = plain_push ? bsd_pkg::PUSH_TWO : bsd_pkg::PUSH_ONE;
                    mode_next = plain_mode;
                end
            end
            default:
            begin
                if (hv.ok)
                begin
                    n         = bsd_pkg::PUSH_ONE;
                    d0        = {hi_reg, hv.val};
                    mode_next = bsd_pkg::MODE_PLAIN;
                end
                else
                begin
                    n         = plain_push ? bsd_pkg::PUSH_TWO : bsd_pkg::PUSH_ONE;
                    d0        = {4'h0, hi_reg};
                    mode_next = plain_mode;
                end
            end
        endcase
        if (mode_next != bsd_pkg::MODE_HEX1)
        begin
            hi_next = 4'h0;
        end
        if (in_last)
        begin
            mode_next = bsd_pkg::MODE_PLAIN;
            hi_next   = 4'h0;
        end
    end

    always_comb
    begin
        push.count       = n;
        push.e0.data     = d0;
        push.e0.run_end  = (n == bsd_pkg::PUSH_ONE);
        push.e0.text_end = (n == bsd_pkg::PUSH_ONE) && in_last;
        push.e1.data     = d1;
        push.e1.run_end  = 1'b1;
        push.e1.text_end = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bsd_pkg::MODE_PLAIN;
            hi_reg   <= 4'h0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hi_reg   <= hi_next;
        end
    end

    assign mode = mode_reg;

endmodule

`default_nettype wire

[hdl/bsd_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsd_out_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire bsd_pkg::push_t push,
    output logic               room,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output bsd_pkg::entry_t    rd_entry,
    output logic [2:0]         count
);

    bsd_pkg::entry_t             mem_reg [bsd_pkg::FIFO_DEPTH];
    logic [bsd_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [bsd_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [2:0]                  count_reg;
    logic [1:0]                  n_wr;
    logic                        pop;
    logic [bsd_pkg::FIFO_AW-1:0] wr_ptr_p1;

    assign n_wr      = wr_en ? push.count : bsd_pkg::PUSH_NONE;
    assign pop       = rd_valid && rd_ready;
    assign wr_ptr_p1 = wr_ptr_reg + {{(bsd_pkg::FIFO_AW-1){1'b0}}, 1'b1};

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (n_wr != bsd_pkg::PUSH_NONE)
        begin
            mem_reg[wr_ptr_reg] <= push.e0;
        end
        if (n_wr == bsd_pkg::PUSH_TWO)
        begin
            mem_reg[wr_ptr_p1] <= push.e1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_wr[bsd_pkg::FIFO_AW-1:0];
            rd_ptr_reg <= rd_ptr_reg + {{(bsd_pkg::FIFO_AW-1){1'b0}}, pop};
            count_reg  <= count_reg + {1'b0, n_wr} - {2'b00, pop};
        end
    end

    assign room     = (count_reg <= bsd_pkg::FIFO_LIMIT);
    assign rd_valid = (count_reg != 3'd0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

`default_nettype wire

[hdl/backslash_escape_decoder_core.sv]
// backslash escape decoder core
//
// input channel (in_valid/in_ready): one raw text byte per transaction in
// in_byte, with in_last high on the final byte of the text
// output channel (out_valid/out_ready): one decoded byte per transaction in
// out_byte; run_end marks the last byte produced by an input transaction and
// text_end marks the final byte of the whole text
//
// an input transaction yields zero, one or two output transactions; its
// results are written into the result queue when the input is taken
// throughput is one input per cycle while in_ready is high, limited by the
// output port, which drains one byte per cycle from a four-entry result
// queue; an input that expands to two bytes therefore takes two transactions
// in_ready is high while at most two entries are queued, so a two-byte
// expansion always fits; a stalled receiver backs up into the input once
// three or four bytes are waiting
// reset clears the decode mode, the held hex digit and the queue; the next
// byte after an in_last transaction starts a fresh text in plain mode
`timescale 1ns / 1ps
`default_nettype none

`include "backslash_escape_decoder_core_macros.svh"

module backslash_escape_decoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_end,
    output logic            text_end
);

    logic            in_fire;
    logic            out_fire;
    bsd_pkg::push_t  push;
    logic [1:0]      mode;
    bsd_pkg::entry_t rd_entry;
    logic [2:0]      count;

    // input transaction taken this cycle
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // decoder state machine: mode and pending hex digit, results go straight
    // to the queue in the same cycle
    bsd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_fire),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .mode    (mode)
    );

    // result queue, two write lanes, one read lane
    bsd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire),
        .push     (push),
        .room     (in_ready),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_entry (rd_entry),
        .count    (count)
    );

    assign out_byte = rd_entry.data;
    assign run_end  = rd_entry.run_end;
    assign text_end = rd_entry.text_end;

    // the final byte of a text always produces something
    `BSD_ASSERT_IMP(a_last_pushes, in_fire && in_last, push.count != bsd_pkg::PUSH_NONE,
        "final byte produced no output")

    // a text end returns the decoder to plain mode
    `BSD_ASSERT_NXT(a_last_plain, in_fire && in_last, mode == bsd_pkg::MODE_PLAIN,
        "decoder not in plain mode after text end")

    // two results only come from escape or hex modes
    `BSD_ASSERT_IMP(a_two_not_plain, in_fire && push.count == bsd_pkg::PUSH_TWO,
        mode != bsd_pkg::MODE_PLAIN, "double output from plain mode")

    // queue never overfills
    `BSD_ASSERT_IMP(a_no_overflow, 1'b1, count <= 3'd4, "result queue overflow")

    // a drain with no new input lowers the fill by one
    `BSD_ASSERT_NXT(a_drain, out_fire && !in_fire, count == $past(count) - 3'd1,
        "queue count did not drop on drain")

endmodule

`default_nettype wire

[verif/escape_decode_checker.sv]
`timescale 1ns / 1ps

module escape_decode_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       run_end,
    input  logic       text_end,
    output int         fail_count,
    output int         pending_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } decoded_t;

    decoded_t   decoded_q[$];
    logic [1:0] esc_mode   = bsd_pkg::MODE_PLAIN;
    logic [3:0] held_digit = 4'h0;
    logic [7:0] result_bytes [0:1];
    int         result_count = 0;
    int         mismatches   = 0;

    // {is digit, value}
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= bsd_pkg::CHAR_0 && c <= bsd_pkg::CHAR_9)
        begin
            v = c - bsd_pkg::CHAR_0;
            return {1'b1, v[3:0]};
        end
        if (c >= bsd_pkg::CHAR_LA && c <= bsd_pkg::CHAR_LF)
        begin
            v = c - bsd_pkg::CHAR_LA + bsd_pkg::HEX_ALPHA;
            return {1'b1, v[3:0]};
        end
        if (c >= bsd_pkg::CHAR_UA && c <= bsd_pkg::CHAR_UF)
        begin
            v = c - bsd_pkg::CHAR_UA + bsd_pkg::HEX_ALPHA;
            return {1'b1, v[3:0]};
        end
        return 5'h00;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        if (result_count < 2)
        begin
            result_bytes[result_count] = b;
            result_count = result_count + 1;
        end
    endtask

    // advance the decoder copy by one input byte and queue what it emits
    task automatic decode_input(input logic [7:0] b, input logic last);
        logic       as_text;
        logic [4:0] dv;
        decoded_t   e;
        as_text      = 1'b0;
        dv           = digit_value(b);
        result_count = 0;
        case (esc_mode)
            bsd_pkg::MODE_PLAIN: as_text = 1'b1;
            bsd_pkg::MODE_ESC:
            begin
                esc_mode = bsd_pkg::MODE_PLAIN;
                case (b)
                    bsd_pkg::CHAR_N:      queue_byte(bsd_pkg::BYTE_NL);
                    bsd_pkg::CHAR_R:      queue_byte(bsd_pkg::BYTE_CR);
                    bsd_pkg::CHAR_T:      queue_byte(bsd_pkg::BYTE_TAB);
                    bsd_pkg::CHAR_E:      queue_byte(bsd_pkg::BYTE_ESC);
                    bsd_pkg::CHAR_BSLASH: queue_byte(bsd_pkg::CHAR_BSLASH);
                    bsd_pkg::CHAR_X:
                    begin
                        if (last)
                            queue_byte(bsd_pkg::CHAR_X);
                        else
                            esc_mode = bsd_pkg::MODE_HEX0;
                    end
                    default:
                    begin
                        queue_byte(bsd_pkg::CHAR_BSLASH);
                        queue_byte(b);
                    end
                endcase
            end
            bsd_pkg::MODE_HEX0:
            begin
                if (dv[4])
                begin
                    if (last)
                    begin
                        queue_byte({4'h0, dv[3:0]});
                        esc_mode = bsd_pkg::MODE_PLAIN;
                    end
                    else
                    begin
                        held_digit = dv[3:0];
                        esc_mode   = bsd_pkg::MODE_HEX1;
                    end
                end
                else
                begin
                    queue_byte(bsd_pkg::CHAR_X);
                    as_text = 1'b1;
                end
            end
            default:
            begin
                if (dv[4])
                begin
                    queue_byte({held_digit, dv[3:0]});
                    esc_mode = bsd_pkg::MODE_PLAIN;
                end
                else
                begin
                    queue_byte({4'h0, held_digit});
                    as_text = 1'b1;
                end
            end
        endcase

        // plain bytes and the byte that ends a short hex escape are handled as text
        if (as_text)
        begin
            if (b == bsd_pkg::CHAR_BSLASH && !last)
                esc_mode = bsd_pkg::MODE_ESC;
            else
            begin
                queue_byte(b);
                esc_mode = bsd_pkg::MODE_PLAIN;
            end
        end

        if (esc_mode != bsd_pkg::MODE_HEX1)
            held_digit = 4'h0;
        if (last)
        begin
            esc_mode   = bsd_pkg::MODE_PLAIN;
            held_digit = 4'h0;
        end

        for (int k = 0; k < result_count; k++)
        begin
            e.data     = result_bytes[k];
            e.run_end  = (k == result_count - 1);
            e.text_end = (k == result_count - 1) && last;
            decoded_q  = {decoded_q, e};
        end
    endtask

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%t: unexpected output byte %h run_end %b text_end %b",
                                 $realtime, out_byte, run_end, text_end);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (want.data !== out_byte || want.run_end !== run_end ||
                        want.text_end !== text_end)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("%t: mismatch expected byte %h run_end %b text_end %b,",
                                   $realtime, want.data, want.run_end, want.text_end);
                            $display(" got byte %h run_end %b text_end %b",
                                     out_byte, run_end, text_end);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                decode_input(in_byte, in_last);
        end
        fail_count    <= mismatches;
        pending_count <= decoded_q.size();
    end

endmodule

[verif/backslash_escape_decoder_core_tb.sv]
`timescale 1ns / 1ps

module backslash_escape_decoder_core_tb;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 2000;   // well above the longest gap or stall
    localparam int DRAIN_CYCLES   = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;

    int fail_count;
    int pending_count;
    int items_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;            // no gaps and no stalls while set

    logic [7:0] text_q[$];

    always #5 clk = ~clk;

    backslash_escape_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .text_end  (text_end)
    );

    // prediction and comparison live in the checker
    escape_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_end       (run_end),
        .text_end      (text_end),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'(bsd_pkg::CHAR_0 + r);
        if (r < 16)
            return 8'(bsd_pkg::CHAR_LA + (r - 10));
        return 8'(bsd_pkg::CHAR_UA + (r - 16));
    endfunction

    // one input transaction; returns at the edge where it is accepted
    // valid is only lowered when a real gap follows, so it never dips between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    // whole text from a string, last flag on the final character
    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_text_q();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic append_char(input logic [7:0] c);
        text_q = {text_q, c};
    endtask

    // one text of random pieces: plain bytes, well-formed escapes and broken ones
    task automatic build_text();
        int pieces;
        text_q.delete();
        pieces = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        repeat (pieces)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    // named escape
                    append_char(bsd_pkg::CHAR_BSLASH);
                    case ($urandom_range(0, 4))
                        0: append_char(bsd_pkg::CHAR_N);
                        1: append_char(bsd_pkg::CHAR_R);
                        2: append_char(bsd_pkg::CHAR_T);
                        3: append_char(bsd_pkg::CHAR_E);
                        default: append_char(bsd_pkg::CHAR_BSLASH);
                    endcase
                end
                3, 4, 5:
                begin
                    // full two-digit hex escape
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(bsd_pkg::CHAR_X);
                    append_char(random_hex_char());
                    append_char(random_hex_char());
                end
                6:
                begin
                    // one digit then any byte
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(bsd_pkg::CHAR_X);
                    append_char(random_hex_char());
                    append_char(8'($urandom_range(0, 255)));
                end
                7:
                begin
                    // one digit then a new escape
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(bsd_pkg::CHAR_X);
                    append_char(random_hex_char());
                    append_char(bsd_pkg::CHAR_BSLASH);
                end
                8:
                begin
                    // x then any byte
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(bsd_pkg::CHAR_X);
                    append_char(8'($urandom_range(0, 255)));
                end
                9:
                begin
                    // escape of an arbitrary byte
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(8'($urandom_range(0, 255)));
                end
                10:
                begin
                    // broken hex escape, whatever follows ends it
                    append_char(bsd_pkg::CHAR_BSLASH);
                    append_char(bsd_pkg::CHAR_X);
                end
                11:
                    append_char(bsd_pkg::CHAR_BSLASH);
                default:
                    append_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // receiver: bursts of ready with random stalls between them
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts
        calm = 1'b1;
        send_string("\\n\\r\\t\\e\\\\");      // every named escape
        calm = 1'b0;
        send_string("\\xfF\\q");             // mixed case hex, unknown escape on last byte
        send_string("\\x5\\xg\\x\\");        // short hex ended by a new escape, bare x ended by text, by end
        send_string("\\x0");                 // one digit then end of text
        send_string("\\x");                  // x as the final byte
        send_string("\\");                   // lone backslash as the final byte

        // random texts, some runs without any idling
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 9) == 0);
            build_text();
            send_text_q();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then let any stray output show up
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
